// ===== rtl/rdcr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rdcr_pkg: shared types and constants of the replacement unit
// Field widths of the request and result channels, access codes and the
// request structure that travels from the controller to the row logic.
// ---------------------------------------------------------------------------
package rdcr_pkg;

  localparam int SET_IDX_W = 11;
  localparam int WAY_IDX_W = 4;
  localparam int TYPE_W    = 2;
  localparam int VICTIM_W  = 4;
  localparam int RDIST_W   = 9;
  localparam int SCORE_W   = 4;

  localparam int DEF_SETS        = 2048;
  localparam int DEF_WAYS        = 16;
  localparam int DEF_AGE_BITS    = 8;
  localparam int DEF_SAMPLE_HITS = 32;

  // Lowest reuse distance the tracker will ever publish.
  localparam int RD_FLOOR = 2;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic [TYPE_W-1:0] TYPE_DEMAND    = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_PREFETCH  = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_WRITEBACK = 2'd2;
  // The unused fourth code behaves as a demand access.
  localparam logic [TYPE_W-1:0] TYPE_RESERVED  = 2'd3;

  // Score weight of a line whose age is still below the reuse distance.
  localparam logic [SCORE_W-1:0] SCORE_NEAR = 4'd8;

  typedef struct packed {
    logic                 kind;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_IDX_W-1:0] way_index;
    logic                 was_hit;
    logic [TYPE_W-1:0]    access_type;
  } req_t;

  typedef struct packed {
    logic wr_en;
    logic hit_rec;
  } row_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/rdcr_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rdcr_if: request and result channels of the replacement unit
// Valid/ready channels; a request moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface rdcr_req_if import rdcr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [SET_IDX_W-1:0] set_index;
  logic [WAY_IDX_W-1:0] way_index;
  logic                 was_hit;
  logic [TYPE_W-1:0]    access_type;

  modport source (output valid, kind, set_index, way_index, was_hit, access_type,
                  input ready);
  modport sink   (input valid, kind, set_index, way_index, was_hit, access_type,
                  output ready);
endinterface

interface rdcr_res_if import rdcr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VICTIM_W-1:0] victim_way;
  logic [RDIST_W-1:0]  reuse_distance;

  modport source (output valid, victim_way, reuse_distance, input ready);
  modport sink   (input valid, victim_way, reuse_distance, output ready);
endinterface
`default_nettype wire

// ===== rtl/rdcr_set_reduce.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rdcr_set_reduce: set index to memory row
// Reduces the incoming set index modulo SETS by a reciprocal multiply, a
// register, then a back multiply with one correcting subtraction.
// ---------------------------------------------------------------------------
module rdcr_set_reduce import rdcr_pkg::*; #(
  parameter int SETS  = DEF_SETS,
  parameter int SET_W = 11
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic [SET_IDX_W-1:0] set_in,
  output logic [SET_W-1:0]     row
);

  localparam int K   = 2 * SET_IDX_W;
  localparam int RW  = K + 1;
  localparam int D_W = $clog2(SETS + 1);
  localparam int CW  = SET_IDX_W + D_W;

  localparam logic [RW-1:0]  RECIP  = RW'((64'd1 << K) / SETS);
  localparam logic [D_W-1:0] SETS_C = D_W'(SETS);

  logic [SET_IDX_W+RW-1:0]  prod;
  logic [SET_IDX_W-1:0]     x_r;
  logic [SET_IDX_W-1:0]     q_r;
  logic [SET_IDX_W+D_W-1:0] qd;
  logic [SET_IDX_W-1:0]     r0;
  logic [CW-1:0]            r0x;
  logic [CW-1:0]            r1;

  // The estimate is the true quotient or one less, never more.
  assign prod = set_in * RECIP;

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= set_in;
      q_r <= prod[K +: SET_IDX_W];
    end
  end

  assign qd  = q_r * SETS_C;
  assign r0  = x_r - qd[SET_IDX_W-1:0];
  assign r0x = CW'(r0);
  assign r1  = (r0x >= CW'(SETS_C)) ? r0x - CW'(SETS_C) : r0x;
  assign row = r1[SET_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/rdcr_row_logic.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rdcr_row_logic: update and victim selection over one set row
// Ages the other ways and rewrites the accessed way for an update, and
// picks the lowest {score, age, way} key through a compare tree for a query.
// ---------------------------------------------------------------------------
module rdcr_row_logic import rdcr_pkg::*; #(
  parameter int WAYS     = DEF_WAYS,
  parameter int AGE_BITS = DEF_AGE_BITS,
  parameter int RD_W     = DEF_AGE_BITS + 1,
  parameter int WAY_W    = 4,
  parameter int LANE_W   = DEF_AGE_BITS + 2
) (
  input  req_t                          req,
  input  logic [WAYS-1:0][LANE_W-1:0]   row_in,
  input  logic [RD_W-1:0]               rd,
  output logic [WAYS-1:0][LANE_W-1:0]   row_out,
  output row_ctl_t                      ctl,
  output logic [AGE_BITS-1:0]           hit_age,
  output logic [WAY_W-1:0]              victim
);

  localparam int KEY_W = SCORE_W + AGE_BITS + WAY_W;
  localparam int P     = 2 ** $clog2(WAYS);
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  logic way_ok;
  logic demand_bit;
  logic [KEY_W-1:0] node [2*P-1];

  assign way_ok     = (32'(req.way_index) < WAYS);
  assign demand_bit = (req.access_type != TYPE_PREFETCH);

  always_comb begin
    ctl.wr_en   = (req.kind == KIND_UPDATE) && way_ok &&
                  !(req.was_hit && (req.access_type == TYPE_WRITEBACK));
    ctl.hit_rec = ctl.wr_en && req.was_hit;
  end

  always_comb begin
    row_out = row_in;
    hit_age = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (32'(req.way_index) == i) begin
        hit_age    = row_in[i][AGE_BITS-1:0];
        row_out[i] = {demand_bit, req.was_hit, {AGE_BITS{1'b0}}};
      end else if (row_in[i][AGE_BITS-1:0] != AGE_MAX) begin
        row_out[i][AGE_BITS-1:0] = row_in[i][AGE_BITS-1:0] + 1'b1;
      end
    end
  end

  // Leaves beyond WAYS hold all ones; a real key never reaches that value
  // because the largest score is ten.
  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < WAYS) begin : g_real
      logic [AGE_BITS-1:0] age;
      logic [SCORE_W-1:0]  score;
      assign age   = row_in[j][AGE_BITS-1:0];
      assign score = ((RD_W'(age) < rd) ? SCORE_NEAR : '0)
                   + SCORE_W'(row_in[j][AGE_BITS])
                   + SCORE_W'(row_in[j][AGE_BITS+1]);
      assign node[P-1+j] = {score, age, WAY_W'(j)};
    end else begin : g_pad
      assign node[P-1+j] = '1;
    end
  end

  for (genvar n = 0; n < P - 1; n++) begin : g_tree
    assign node[n] = (node[2*n+2] < node[2*n+1]) ? node[2*n+2] : node[2*n+1];
  end

  assign victim = node[0][WAY_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/rdcr_tracker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rdcr_tracker: global reuse distance tracker
// Sums hit ages over a sample of hits, then divides twice the sum by the
// sample size in a short multiply-and-correct pipeline.
// ---------------------------------------------------------------------------
module rdcr_tracker import rdcr_pkg::*; #(
  parameter int AGE_BITS    = DEF_AGE_BITS,
  parameter int SAMPLE_HITS = DEF_SAMPLE_HITS,
  parameter int RD_W        = DEF_AGE_BITS + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                hit_rec,
  input  logic [AGE_BITS-1:0] hit_age,
  output logic [RD_W-1:0]     rd
);

  localparam int CNT_W = $clog2(SAMPLE_HITS);
  localparam int SUM_W = AGE_BITS + CNT_W;
  localparam int V_W   = SUM_W + 1;

  localparam logic [V_W-1:0]   RECIP   = V_W'((64'd1 << V_W) / SAMPLE_HITS);
  localparam logic [V_W-1:0]   SH_C    = V_W'(SAMPLE_HITS);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SAMPLE_HITS - 1);
  localparam logic [RD_W-1:0]  RD_MIN  = RD_W'(RD_FLOOR);

  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    sum_nxt;
  logic [V_W-1:0]      v_r;
  logic                go1_r;
  logic                go2_r;
  logic [RD_W-1:0]     q_r;
  logic [RD_W-1:0]     rd_r;
  logic [2*V_W-1:0]    prod;
  logic [RD_W+V_W-1:0] qd;
  logic [V_W-1:0]      rem;
  logic [RD_W-1:0]     qc;

  assign sum_nxt = sum_r + SUM_W'(hit_age);
  assign prod    = v_r * RECIP;
  assign qd      = q_r * SH_C;
  assign rem     = v_r - qd[V_W-1:0];
  assign qc      = (rem >= SH_C) ? q_r + 1'b1 : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      go1_r <= 1'b0;
      go2_r <= 1'b0;
      rd_r  <= RD_MIN;
    end else begin
      go1_r <= 1'b0;
      go2_r <= go1_r;
      if (hit_rec) begin
        if (cnt_r == CNT_END) begin
          cnt_r <= '0;
          sum_r <= '0;
          v_r   <= {sum_nxt, 1'b0};
          go1_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
          sum_r <= sum_nxt;
        end
      end
      // The estimate may fall one short; the back multiply corrects it.
      if (go1_r) begin
        q_r <= prod[V_W +: RD_W];
      end
      if (go2_r) begin
        rd_r <= (qc < RD_MIN) ? RD_MIN : qc;
      end
    end
  end

  assign rd = rd_r;

endmodule
`default_nettype wire

// ===== rtl/reuse_distance_cache_replacement_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// reuse_distance_cache_replacement_unit: low-reuse replacement policy
// Per-set row memory with read-modify-write updates and victim selection.
// ---------------------------------------------------------------------------
// Flow: an accepted request loads the set reduction register, S_ADDR reads the row of
// the single row memory into a register, and in S_EXEC a query loads the result
// registers while an update writes the row back. No new request is taken before the
// unit returns to S_IDLE; a query waits in S_EXEC while the previous result is unread.
// Reset: after rst_n the row memory is cleared one set per cycle, with ready held low
// until the pass ends.
module reuse_distance_cache_replacement_unit import rdcr_pkg::*; #(
  parameter int SETS        = DEF_SETS,
  parameter int WAYS        = DEF_WAYS,
  parameter int AGE_BITS    = DEF_AGE_BITS,
  parameter int SAMPLE_HITS = DEF_SAMPLE_HITS
) (
  input  logic         clk,
  input  logic         rst_n,
  rdcr_req_if.sink     in_req,
  rdcr_res_if.source   out_res
);

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int LANE_W = AGE_BITS + 2;
  localparam int RD_W   = AGE_BITS + 1;
  localparam int VX_W   = (WAY_W > VICTIM_W) ? WAY_W : VICTIM_W;
  localparam int RX_W   = (RD_W > RDIST_W) ? RD_W : RDIST_W;

  localparam logic [LANE_W-1:0] LANE_RESET = {1'b1, 1'b0, {AGE_BITS{1'b0}}};
  localparam logic [SET_W-1:0]  CLR_LAST   = SET_W'(SETS - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_ADDR  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [SET_W-1:0]              clr_cnt_r;
  req_t                          req_r;
  logic                          accept;
  logic [SET_W-1:0]              row_addr;
  logic [WAYS-1:0][LANE_W-1:0]   mem [SETS];
  logic [WAYS-1:0][LANE_W-1:0]   rd_data_r;
  logic [WAYS-1:0][LANE_W-1:0]   row_nxt;
  logic                          mem_we;
  logic [SET_W-1:0]              mem_waddr;
  logic [WAYS-1:0][LANE_W-1:0]   mem_wdata;
  row_ctl_t                      ctl;
  logic [AGE_BITS-1:0]           hit_age;
  logic [WAY_W-1:0]              victim;
  logic [RD_W-1:0]               rd;
  logic [VX_W-1:0]               victim_x;
  logic [RX_W-1:0]               rd_x;
  logic                          slot_free;
  logic                          out_load;
  logic                          out_valid_r;
  logic [VICTIM_W-1:0]           out_victim_r;
  logic [RDIST_W-1:0]            out_rd_r;

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;

  rdcr_set_reduce #(
    .SETS  (SETS),
    .SET_W (SET_W)
  ) u_set_reduce (
    .clk    (clk),
    .load   (accept),
    .set_in (in_req.set_index),
    .row    (row_addr)
  );

  rdcr_row_logic #(
    .WAYS     (WAYS),
    .AGE_BITS (AGE_BITS),
    .RD_W     (RD_W),
    .WAY_W    (WAY_W),
    .LANE_W   (LANE_W)
  ) u_row_logic (
    .req     (req_r),
    .row_in  (rd_data_r),
    .rd      (rd),
    .row_out (row_nxt),
    .ctl     (ctl),
    .hit_age (hit_age),
    .victim  (victim)
  );

  rdcr_tracker #(
    .AGE_BITS    (AGE_BITS),
    .SAMPLE_HITS (SAMPLE_HITS),
    .RD_W        (RD_W)
  ) u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .hit_rec ((state_r == S_EXEC) && ctl.hit_rec),
    .hit_age (hit_age),
    .rd      (rd)
  );

  assign slot_free = !out_valid_r || out_res.ready;
  assign out_load  = (state_r == S_EXEC) && (req_r.kind == KIND_QUERY) && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == CLR_LAST) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_EXEC;
      S_EXEC: begin
        // A query waits here while the previous result is still unread.
        if (req_r.kind == KIND_UPDATE || slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = {WAYS{LANE_RESET}};
    end else begin
      mem_we    = (state_r == S_EXEC) && ctl.wr_en;
      mem_waddr = row_addr;
      mem_wdata = row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == S_ADDR) begin
      rd_data_r <= mem[row_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.kind        <= in_req.kind;
      req_r.set_index   <= in_req.set_index;
      req_r.way_index   <= in_req.way_index;
      req_r.was_hit     <= in_req.was_hit;
      req_r.access_type <= in_req.access_type;
    end
    if (out_load) begin
      out_victim_r <= victim_x[VICTIM_W-1:0];
      out_rd_r     <= rd_x[RDIST_W-1:0];
    end
  end

  assign victim_x = VX_W'(victim);
  assign rd_x     = RX_W'(rd);

  assign out_res.valid          = out_valid_r;
  assign out_res.victim_way     = out_victim_r;
  assign out_res.reuse_distance = out_rd_r;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the reuse-distance replacement unit
// A driver feeds access updates and victim queries from a queue filled at
// time zero; a monitor replays every accepted request on a local model of
// the per-line ages, hit and demand bits and the global reuse tracker, and
// checks each victim result against the oldest predicted one.
// ---------------------------------------------------------------------------
module tb import rdcr_pkg::*;;

  localparam int SETS        = DEF_SETS;
  localparam int WAYS        = DEF_WAYS;
  localparam int AGE_BITS    = DEF_AGE_BITS;
  localparam int SAMPLE_HITS = DEF_SAMPLE_HITS;
  localparam int AGE_MAX     = (1 << AGE_BITS) - 1;

  typedef struct packed {
    logic [VICTIM_W-1:0] way;
    logic [RDIST_W-1:0]  rdist;
  } victim_t;

  typedef struct {
    req_t        req;
    int unsigned gap;
    bit          drain;
  } pend_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rdcr_req_if in_if ();
  rdcr_res_if out_if ();

  reuse_distance_cache_replacement_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_if.sink),
    .out_res (out_if.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local copy of the replacement state.
  logic [AGE_BITS-1:0] age_mem    [SETS*WAYS];
  bit                  had_hit_mem[SETS*WAYS];
  bit                  demand_mem [SETS*WAYS];
  int unsigned         rd_cur;
  int unsigned         age_acc;
  int unsigned         hits_seen;

  pend_t       req_q[$];
  victim_t     victim_q[$];
  int unsigned outstanding;
  int unsigned failures;
  int unsigned updates_seen;
  int unsigned queries_seen;
  int unsigned rd_peak;

  // Generator bookkeeping, used only while the request queue is filled.
  bit          quiet;
  bit          hold_next;
  int unsigned gen_hits;

  function automatic int unsigned line_score(input int unsigned idx);
    int unsigned s;
    s = (age_mem[idx] < rd_cur) ? int'(SCORE_NEAR) : 0;
    return s + 32'(had_hit_mem[idx]) + 32'(demand_mem[idx]);
  endfunction

  task automatic apply_request(input req_t r);
    int unsigned base;
    int unsigned idx;
    int unsigned best;
    int unsigned best_s;
    int unsigned best_a;
    int unsigned s;
    victim_t     v;
    base = (r.set_index % SETS) * WAYS;
    if (r.kind == KIND_QUERY) begin
      best   = 0;
      best_s = line_score(base);
      best_a = 32'(age_mem[base]);
      for (int w = 1; w < WAYS; w++) begin
        s = line_score(base + w);
        if (s < best_s || (s == best_s && age_mem[base + w] < best_a)) begin
          best   = w;
          best_s = s;
          best_a = 32'(age_mem[base + w]);
        end
      end
      v.way    = VICTIM_W'(best);
      v.rdist  = RDIST_W'(rd_cur);
      victim_q = {victim_q, v};
      queries_seen++;
    end else begin
      updates_seen++;
      if (r.way_index < WAYS && !(r.was_hit && r.access_type == TYPE_WRITEBACK)) begin
        for (int w = 0; w < WAYS; w++) begin
          if (w != r.way_index && age_mem[base + w] != AGE_MAX)
            age_mem[base + w] = age_mem[base + w] + 1'b1;
        end
        idx = base + r.way_index;
        if (r.was_hit) begin
          age_acc += 32'(age_mem[idx]);
          hits_seen++;
          if (hits_seen >= SAMPLE_HITS) begin
            rd_cur = (2 * age_acc) / SAMPLE_HITS;
            if (rd_cur < RD_FLOOR)
              rd_cur = RD_FLOOR;
            age_acc   = 0;
            hits_seen = 0;
          end
        end
        age_mem[idx]     = '0;
        had_hit_mem[idx] = r.was_hit;
        demand_mem[idx]  = (r.access_type != TYPE_PREFETCH);
      end
    end
  endtask

  task automatic note_failure(input string msg);
    if (failures < 10)
      $display("%s", msg);
    failures++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 60);
  endfunction

  task automatic push_req(input logic kind, input int unsigned set, input int unsigned way,
                          input logic hit, input logic [TYPE_W-1:0] typ);
    pend_t p;
    p.req.kind        = kind;
    p.req.set_index   = SET_IDX_W'(set);
    p.req.way_index   = WAY_IDX_W'(way);
    p.req.was_hit     = hit;
    p.req.access_type = typ;
    p.gap             = quiet ? 0 : pick_gap();
    p.drain           = hold_next;
    hold_next         = 1'b0;
    if (kind == KIND_UPDATE && hit && typ != TYPE_WRITEBACK)
      gen_hits++;
    req_q = {req_q, p};
  endtask

  // Queries carry random way, hit and type bits, which the block must ignore.
  task automatic push_random(input int unsigned set);
    int unsigned way;
    way = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 3) : $urandom_range(0, WAYS - 1);
    if ($urandom_range(0, 99) < 30)
      push_req(KIND_QUERY, set, way, 1'($urandom_range(0, 1)),
               TYPE_W'($urandom_range(0, 3)));
    else
      push_req(KIND_UPDATE, set, way, $urandom_range(0, 99) < 60,
               TYPE_W'($urandom_range(0, 3)));
  endtask

  // Driver: one request at a time, with a random gap, possibly none, after each.
  int unsigned gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left    <= 0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      if (gap_left != 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (req_q.size() != 0 &&
                   (!req_q[0].drain || (!in_if.valid && outstanding == 0))) begin
        in_if.valid       <= 1'b1;
        in_if.kind        <= req_q[0].req.kind;
        in_if.set_index   <= req_q[0].req.set_index;
        in_if.way_index   <= req_q[0].req.way_index;
        in_if.was_hit     <= req_q[0].req.was_hit;
        in_if.access_type <= req_q[0].req.access_type;
        gap_left          <= req_q[0].gap;
        void'(req_q.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: mostly short open runs and short stalls, sometimes long ones of either.
  int unsigned rdy_left;

  always @(posedge clk) begin : result_stall
    int unsigned r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rdy_left     <= 0;
    end else if (rdy_left != 0) begin
      rdy_left <= rdy_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_if.ready <= 1'b1;
        rdy_left     <= $urandom_range(0, 15);
      end else if (r < 70) begin
        out_if.ready <= 1'b1;
        rdy_left     <= $urandom_range(50, 200);
      end else if (r < 95) begin
        out_if.ready <= 1'b0;
        rdy_left     <= $urandom_range(0, 3);
      end else begin
        out_if.ready <= 1'b0;
        rdy_left     <= $urandom_range(10, 40);
      end
    end
  end

  // Monitor: results are checked before the request of the same edge is predicted.
  always @(posedge clk) begin : monitor
    victim_t got;
    victim_t want;
    req_t    req;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.way   = out_if.victim_way;
        got.rdist = out_if.reuse_distance;
        if (got.rdist > rd_peak)
          rd_peak = 32'(got.rdist);
        if (victim_q.size() == 0) begin
          note_failure($sformatf("tb: unexpected result way %0d rd %0d",
                                 got.way, got.rdist));
        end else begin
          want = victim_q.pop_front();
          if (got.way !== want.way || got.rdist !== want.rdist)
            note_failure($sformatf("tb: mismatch way exp %0d got %0d, rd exp %0d got %0d",
                                   want.way, got.way, want.rdist, got.rdist));
        end
      end
      if (in_if.valid && in_if.ready) begin
        req.kind        = in_if.kind;
        req.set_index   = in_if.set_index;
        req.way_index   = in_if.way_index;
        req.was_hit     = in_if.was_hit;
        req.access_type = in_if.access_type;
        apply_request(req);
      end
      outstanding <= victim_q.size();
    end
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    int unsigned hot[4];
    int unsigned set;
    for (int i = 0; i < SETS * WAYS; i++) begin
      age_mem[i]     = '0;
      had_hit_mem[i] = 1'b0;
      demand_mem[i]  = 1'b1;
    end
    rd_cur            = RD_FLOOR;
    age_acc           = 0;
    hits_seen         = 0;
    outstanding       = 0;
    failures          = 0;
    updates_seen      = 0;
    queries_seen      = 0;
    rd_peak           = 0;
    quiet             = 1'b0;
    hold_next         = 1'b0;
    gen_hits          = 0;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_UPDATE;
    in_if.set_index   = '0;
    in_if.way_index   = '0;
    in_if.was_hit     = 1'b0;
    in_if.access_type = TYPE_DEMAND;
    out_if.ready      = 1'b0;

    // Directed: reset state, both set extremes, every access type, writeback hit and miss.
    push_req(KIND_QUERY,  0,    0,  1'b0, TYPE_DEMAND);
    push_req(KIND_QUERY,  2047, 15, 1'b1, TYPE_RESERVED);
    push_req(KIND_UPDATE, 2047, 15, 1'b0, TYPE_PREFETCH);
    push_req(KIND_QUERY,  2047, 0,  1'b0, TYPE_DEMAND);
    push_req(KIND_UPDATE, 2047, 3,  1'b1, TYPE_DEMAND);
    push_req(KIND_UPDATE, 2047, 4,  1'b1, TYPE_WRITEBACK);
    push_req(KIND_UPDATE, 2047, 5,  1'b0, TYPE_WRITEBACK);
    push_req(KIND_UPDATE, 2047, 7,  1'b1, TYPE_RESERVED);
    push_req(KIND_UPDATE, 2047, 8,  1'b0, TYPE_RESERVED);
    push_req(KIND_UPDATE, 2047, 9,  1'b1, TYPE_PREFETCH);
    push_req(KIND_QUERY,  2047, 0,  1'b0, TYPE_DEMAND);
    push_req(KIND_UPDATE, 0,    0,  1'b1, TYPE_PREFETCH);
    push_req(KIND_UPDATE, 0,    15, 1'b0, TYPE_DEMAND);
    push_req(KIND_UPDATE, 0,    15, 1'b1, TYPE_WRITEBACK);
    push_req(KIND_QUERY,  0,    0,  1'b0, TYPE_DEMAND);
    push_req(KIND_UPDATE, 1365, 10, 1'b1, TYPE_DEMAND);
    push_req(KIND_UPDATE, 682,  5,  1'b0, TYPE_PREFETCH);
    push_req(KIND_QUERY,  1365, 5,  1'b1, TYPE_PREFETCH);
    push_req(KIND_QUERY,  682,  10, 1'b0, TYPE_WRITEBACK);
    push_req(KIND_QUERY,  2047, 0,  1'b0, TYPE_DEMAND);

    // Random, concentrated on a few sets so that ages build up and the tracker moves.
    hot = '{0, 2047, 1365, 682};
    for (int i = 0; i < 500; i++) begin
      if (i % 100 == 0)
        quiet = ($urandom_range(0, 3) == 0);
      set = ($urandom_range(0, 99) < 85) ? hot[$urandom_range(0, 3)]
                                         : $urandom_range(0, SETS - 1);
      push_random(set);
    end
    quiet = 1'b0;

    // Hold off until every query has been answered, then line up a fresh hit sample.
    hold_next = 1'b1;
    while (gen_hits % SAMPLE_HITS != 0)
      push_req(KIND_UPDATE, 5, $urandom_range(0, WAYS - 1), 1'b1, TYPE_DEMAND);

    // Saturate the ages of three sets, then take a full sample of hits at the maximum age.
    for (int s = 100; s < 103; s++) begin
      for (int i = 0; i < 256; i++) begin
        push_req(KIND_UPDATE, s, 0, 1'($urandom_range(0, 1)), TYPE_DEMAND);
        if (i % 64 == 63)
          push_req(KIND_QUERY, s, 0, 1'b0, TYPE_DEMAND);
      end
    end
    for (int i = 0; i < SAMPLE_HITS; i++)
      push_req(KIND_UPDATE, 100 + i / 15, 1 + i % 15, 1'b1,
               $urandom_range(0, 1) ? TYPE_RESERVED : TYPE_DEMAND);
    push_req(KIND_QUERY, 100, 0, 1'b0, TYPE_DEMAND);
    push_req(KIND_QUERY, 102, 0, 1'b0, TYPE_DEMAND);

    hold_next = 1'b1;
    hot = '{100, 101, 102, 2047};
    for (int i = 0; i < 600; i++) begin
      if (i % 100 == 0)
        quiet = ($urandom_range(0, 3) == 0);
      set = ($urandom_range(0, 99) < 75) ? hot[$urandom_range(0, 3)]
                                         : $urandom_range(0, SETS - 1);
      push_random(set);
    end
    quiet = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_if.valid || outstanding != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
    if (victim_q.size() != 0)
      note_failure($sformatf("tb: %0d results never arrived", victim_q.size()));

    $display("tb: %0d updates and %0d victim queries checked, reuse distance reached %0d",
             updates_seen, queries_seen, rd_peak);
    if (failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: %0d failures", failures);
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rdcr_pkg.sv
rtl/rdcr_if.sv
rtl/rdcr_set_reduce.sv
rtl/rdcr_row_logic.sv
rtl/rdcr_tracker.sv
rtl/reuse_distance_cache_replacement_unit.sv
test/tb.sv
